// ----- hdl/gaf_pkg.sv -----
// Shared constants and result type for the grid anchor finder.
`timescale 1ns / 1ps
package gaf_pkg;

  // Fixed field widths of the channels
  localparam int CoordBits = 8;
  localparam int OutIdxBits = 16;
  localparam int CfgBits = 16;

  // One result item as held in the output register
  typedef struct packed {
    logic                  entry_made;
    logic                  is_anchor;
    logic                  point_appended;
    logic [OutIdxBits-1:0] entry_index;
    logic                  down_valid;
    logic [OutIdxBits-1:0] down_index;
    logic                  left_valid;
    logic [OutIdxBits-1:0] left_index;
  } result_t;

endpackage

// ----- hdl/gaf_if.sv -----
// Valid/ready channel interfaces for cells in and results out.
`timescale 1ns / 1ps
interface gaf_cell_if import gaf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] cell_column;
  logic [CoordBits-1:0] cell_row;
  logic                 is_support_point;

  modport source (output valid, cell_column, cell_row, is_support_point, input ready);
  modport sink (input valid, cell_column, cell_row, is_support_point, output ready);
endinterface

interface gaf_result_if import gaf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  entry_made;
  logic                  is_anchor;
  logic                  point_appended;
  logic [OutIdxBits-1:0] entry_index;
  logic                  down_valid;
  logic [OutIdxBits-1:0] down_index;
  logic                  left_valid;
  logic [OutIdxBits-1:0] left_index;

  modport source (output valid, entry_made, is_anchor, point_appended, entry_index,
                  down_valid, down_index, left_valid, left_index, input ready);
  modport sink (input valid, entry_made, is_anchor, point_appended, entry_index,
                down_valid, down_index, left_valid, left_index, output ready);
endinterface

// ----- hdl/gaf_line_mem.sv -----
// Per-line tracker: occupied bits plus last-entry index memory with forwarding.
`timescale 1ns / 1ps
module gaf_line_mem import gaf_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int IW    = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // read issue, registered ahead of use
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  // lookup result for the last issued read
  output logic                     has_entry,
  output logic [IW-1:0]            last_entry,
  // write back
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [IW-1:0]            wr_data
);

  localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2);

  logic [IW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] occ_r;
  logic [AW-1:0]    rd_addr_r;
  logic [IW-1:0]    rd_data_r;
  logic             fwd_valid_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [IW-1:0]    fwd_data_r;

  // index memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // occupied bits and last write, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      fwd_valid_r <= 1'b0;
    end else if (wr_en) begin
      occ_r[wr_addr] <= 1'b1;
      fwd_valid_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

  // a write on the read edge is missed by the memory: take it from the last write
  assign has_entry  = occ_r[rd_addr_r];
  assign last_entry = (fwd_valid_r && (fwd_addr_r == rd_addr_r)) ? fwd_data_r : rd_data_r;

endmodule

// ----- hdl/grid_anchor_finder.sv -----
// Top level: grid anchor finder with column and row trackers.
//
//  channel  | direction | transfer when        | carries
//  in_cell  | sink      | valid && ready       | cell_column, cell_row, is_support_point
//  out_res  | source    | valid && ready       | entry flags, entry/down/left indices
//  cfg_*    | write     | cfg_wr_en            | support_point_count
//
// One cell is taken per cycle while the output does not stall. The cell transfer
// loads stage two, and stage two advancing loads the output register that offers the result.
// The cell transfer edge issues the column and row memory reads; stage two decides,
// writes back and loads the output register. The write of one cell and the read of
// the next meet on the same edge and are resolved by forwarding the last write.
// Reset (synchronous) clears the occupied bits and counters at once; no sweep.
// A stalled output holds stage two, which in turn drops in_cell.ready.
`timescale 1ns / 1ps
module grid_anchor_finder import gaf_pkg::*; #(
  parameter int GRID_COLUMNS = 256,
  parameter int GRID_ROWS    = 256,
  parameter int INDEX_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  gaf_cell_if.sink            in_cell,
  gaf_result_if.source        out_res,
  input  logic                cfg_wr_en,
  input  logic [CfgBits-1:0]  cfg_wr_data
);

  localparam int CAW = $clog2(GRID_COLUMNS > 1 ? GRID_COLUMNS : 2);
  localparam int RAW = $clog2(GRID_ROWS > 1 ? GRID_ROWS : 2);

  logic [CfgBits-1:0]    spc_r;
  logic [INDEX_BITS-1:0] next_sup_r, next_sup_nxt;
  logic [INDEX_BITS-1:0] app_cnt_r, app_cnt_nxt;

  logic                  s1_valid_r;
  logic                  s1_in_range_r;
  logic                  s1_sp_r;
  logic [CAW-1:0]        s1_col_r;
  logic [RAW-1:0]        s1_row_r;

  logic                  out_valid_r;
  result_t               out_r, out_nxt;

  logic                  in_xfer, s1_adv;
  logic                  in_range;
  logic [CAW+7:0]        col_ext;
  logic [RAW+7:0]        row_ext;
  logic [CAW-1:0]        col_addr;
  logic [RAW-1:0]        row_addr;

  logic                  col_has, row_has;
  logic [INDEX_BITS-1:0] col_last, row_last;
  logic                  anchor, make;
  logic [INDEX_BITS-1:0] spc_idx, idx;
  logic [INDEX_BITS+15:0] spc_wide, idx_wide, col_wide, row_wide;

  // handshake
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_cell.ready = !s1_valid_r || s1_adv;
  assign in_xfer      = in_cell.valid && in_cell.ready;

  // address forming and grid range check
  assign col_ext  = (CAW + 8)'(in_cell.cell_column);
  assign row_ext  = (RAW + 8)'(in_cell.cell_row);
  assign col_addr = col_ext[CAW-1:0];
  assign row_addr = row_ext[RAW-1:0];
  assign in_range = (32'(in_cell.cell_column) < 32'(GRID_COLUMNS)) &&
                    (32'(in_cell.cell_row) < 32'(GRID_ROWS));

  // column and row trackers
  gaf_line_mem #(.DEPTH(GRID_COLUMNS), .IW(INDEX_BITS)) u_col (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_xfer),
    .rd_addr    (col_addr),
    .has_entry  (col_has),
    .last_entry (col_last),
    .wr_en      (s1_adv && make),
    .wr_addr    (s1_col_r),
    .wr_data    (idx)
  );

  gaf_line_mem #(.DEPTH(GRID_ROWS), .IW(INDEX_BITS)) u_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_xfer),
    .rd_addr    (row_addr),
    .has_entry  (row_has),
    .last_entry (row_last),
    .wr_en      (s1_adv && make),
    .wr_addr    (s1_row_r),
    .wr_data    (idx)
  );

  // anchor decision and index choice
  assign anchor   = s1_in_range_r &&
                    ((col_has && row_has) || (s1_sp_r && (col_has || row_has)));
  assign make     = s1_in_range_r && (s1_sp_r || anchor);
  assign spc_wide = (INDEX_BITS + 16)'(spc_r);
  assign spc_idx  = spc_wide[INDEX_BITS-1:0];
  assign idx      = s1_sp_r ? next_sup_r : (spc_idx + app_cnt_r);
  assign idx_wide = (INDEX_BITS + 16)'(idx);
  assign col_wide = (INDEX_BITS + 16)'(col_last);
  assign row_wide = (INDEX_BITS + 16)'(row_last);

  always_comb begin
    next_sup_nxt = next_sup_r;
    app_cnt_nxt  = app_cnt_r;
    if (s1_adv && make) begin
      if (s1_sp_r) begin
        next_sup_nxt = next_sup_r + 1'b1;
      end else begin
        app_cnt_nxt = app_cnt_r + 1'b1;
      end
    end
  end

  // result fields, all zero when no entry is made
  always_comb begin
    out_nxt                = '0;
    out_nxt.entry_made     = make;
    out_nxt.is_anchor      = anchor;
    out_nxt.point_appended = make && !s1_sp_r;
    if (make) begin
      out_nxt.entry_index = idx_wide[OutIdxBits-1:0];
      out_nxt.down_valid  = col_has;
      out_nxt.left_valid  = row_has;
      if (col_has) begin
        out_nxt.down_index = col_wide[OutIdxBits-1:0];
      end
      if (row_has) begin
        out_nxt.left_index = row_wide[OutIdxBits-1:0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r       <= '0;
      next_sup_r  <= '0;
      app_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        spc_r <= cfg_wr_data;
      end
      next_sup_r <= next_sup_nxt;
      app_cnt_r  <= app_cnt_nxt;
      if (in_cell.ready) begin
        s1_valid_r <= in_cell.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_in_range_r <= in_range;
      s1_sp_r       <= in_cell.is_support_point;
      s1_col_r      <= col_addr;
      s1_row_r      <= row_addr;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  // output channel
  assign out_res.valid          = out_valid_r;
  assign out_res.entry_made     = out_r.entry_made;
  assign out_res.is_anchor      = out_r.is_anchor;
  assign out_res.point_appended = out_r.point_appended;
  assign out_res.entry_index    = out_r.entry_index;
  assign out_res.down_valid     = out_r.down_valid;
  assign out_res.down_index     = out_r.down_index;
  assign out_res.left_valid     = out_r.left_valid;
  assign out_res.left_index     = out_r.left_index;

endmodule
